[rtl/tbrl_pkg.sv]
package tbrl_pkg;

   localparam int RATE_BITS    = 40;
   localparam int TOK_BITS     = RATE_BITS - 1;
   localparam int TIME_BITS    = 48;
   localparam int BYTES_BITS   = 40;
   localparam int LEVEL_BITS   = 39;
   localparam int ELAPSED_BITS = 9;
   localparam int BUCKET_MS    = 500;
   localparam int MS_PER_S     = 1000;
   localparam int PROD_BITS    = RATE_BITS + ELAPSED_BITS;
   localparam int DIG_BITS     = 7;
   localparam int NUM_DIGITS   = (PROD_BITS + DIG_BITS - 1) / DIG_BITS;
   localparam int WORK_BITS    = NUM_DIGITS * DIG_BITS;
   localparam int REM_BITS     = 10;
   localparam int MQ_DEPTH     = 16;
   localparam int OQ_DEPTH     = 2;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_WAIT  = 3'd1,
      ST_OK    = 3'd2,
      ST_ABORT = 3'd3,
      ST_BUSY  = 3'd4
   } status_type;

   typedef struct packed {
      logic                  req_type;
      logic [TIME_BITS-1:0]  now_ms;
      logic [BYTES_BITS-1:0] request_bytes;
      logic                  cancel;
      logic                  pause;
   } tbrl_req_type;

   typedef struct packed {
      status_type            status;
      logic [BYTES_BITS-1:0] granted_bytes;
      logic [BYTES_BITS-1:0] bytes_left;
      logic [LEVEL_BITS-1:0] token_level;
   } tbrl_rsp_type;

   typedef struct packed {
      logic                  acquire;
      logic                  stop;
      logic [BYTES_BITS-1:0] request_bytes;
      logic                  refill;
   } tbrl_meta_type;

   typedef struct packed {
      tbrl_meta_type           meta;
      logic [ELAPSED_BITS-1:0] elapsed;
      logic [WORK_BITS-1:0]    work;
      logic [REM_BITS-1:0]     rem;
   } tbrl_stage_type;

   typedef struct packed {
      tbrl_meta_type        meta;
      logic [TOK_BITS-1:0]  add;
   } tbrl_item_type;

endpackage

[rtl/token_bucket_rate_limiter_unit.sv]
// Byte-rate token bucket. Push tick items (req_type 0, millisecond timestamp) and acquire items
// (req_type 1, byte count); every accepted item gives exactly one result, in order. A tick adds
// rate*elapsed/1000 tokens, elapsed capped at 500 ms, and the bucket holds at most half a second
// of tokens; one acquire may be outstanding and each later step grants it what the bucket holds.
// The block takes one item per clock and delivers one result per clock while rsp_pop keeps up.
// An item passes through the front pipeline stages (elapsed time, one rate multiply, then the
// divide by one thousand at one 7-bit quotient digit per stage), waits in a 16-entry queue, and
// is applied to the bucket as it leaves that queue before landing in a two-entry result queue;
// req_full rises once sixteen items are between the input and the back end. Write csr_wdata
// (rate in bytes per second, zero for no limit) only while no item is in flight.
module token_bucket_rate_limiter_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  tbrl_pkg::tbrl_req_type         req_data,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output tbrl_pkg::tbrl_rsp_type         rsp_data,
   input  logic                           csr_we,
   input  logic [tbrl_pkg::RATE_BITS-1:0] csr_wdata
);

   import tbrl_pkg::*;

   logic [RATE_BITS-1:0] rate_ff, rate_in;
   logic                 item_push;
   tbrl_item_type        item_wdata;
   tbrl_item_type        item_rdata;
   logic                 item_empty;
   logic                 item_pop;
   logic                 out_push;
   logic                 out_full;
   tbrl_rsp_type         out_data;

   assign rate_in = csr_we ? csr_wdata : rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= '0;
      end else begin
         rate_ff <= rate_in;
      end
   end

   tbrl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rate      (rate_ff),
      .deq       (item_pop),
      .item_push (item_push),
      .item_data (item_wdata)
   );

   tbrl_queue #(
      .WIDTH ($bits(tbrl_item_type)),
      .DEPTH (MQ_DEPTH)
   ) u_item_queue (
      .clock (clock),
      .reset (reset),
      .push  (item_push),
      .wdata (item_wdata),
      .pop   (item_pop),
      .rdata (item_rdata),
      .empty (item_empty),
      .full  ()
   );

   tbrl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .rate       (rate_ff),
      .item_empty (item_empty),
      .item_data  (item_rdata),
      .item_pop   (item_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_data   (out_data)
   );

   tbrl_queue #(
      .WIDTH ($bits(tbrl_rsp_type)),
      .DEPTH (OQ_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_data),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty),
      .full  (out_full)
   );

endmodule

[rtl/tbrl_queue.sv]
module tbrl_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty,
   output logic             full
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == CNT_BITS'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[rtl/tbrl_front.sv]
module tbrl_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  tbrl_pkg::tbrl_req_type         req_data,
   input  logic [tbrl_pkg::RATE_BITS-1:0] rate,
   input  logic                           deq,
   output logic                           item_push,
   output tbrl_pkg::tbrl_item_type        item_data
);

   import tbrl_pkg::*;

   localparam int NUM_STAGES = NUM_DIGITS + 2;
   localparam int LAST       = NUM_STAGES - 1;
   localparam int CNT_BITS   = $clog2(MQ_DEPTH + 1);
   localparam int V_BITS     = REM_BITS + DIG_BITS;

   logic                  accept;
   logic                  started_ff, started_in;
   logic [TIME_BITS-1:0]  last_ff, last_in;
   logic [TIME_BITS-1:0]  elapsed_full;
   logic [CNT_BITS-1:0]   used_ff, used_in;
   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   tbrl_stage_type        st_ff [NUM_STAGES];
   tbrl_stage_type        st_in [NUM_STAGES];
   tbrl_stage_type        head;

   // one quotient digit of the divide by one thousand
   function automatic tbrl_stage_type div_step(input tbrl_stage_type s);
      logic [V_BITS-1:0]   v;
      logic [DIG_BITS-1:0] q;
      tbrl_stage_type      r;
      r = s;
      v = {s.rem, s.work[WORK_BITS-1 -: DIG_BITS]};
      q = '0;
      for (int i = DIG_BITS - 1; i >= 0; i--) begin
         if (v >= (V_BITS'(MS_PER_S) << i)) begin
            v    = v - (V_BITS'(MS_PER_S) << i);
            q[i] = 1'b1;
         end
      end
      r.rem  = v[REM_BITS-1:0];
      r.work = {s.work[WORK_BITS-DIG_BITS-1:0], q};
      return r;
   endfunction

   assign accept       = req_push && !req_full;
   assign req_full     = (used_ff == CNT_BITS'(MQ_DEPTH));
   assign elapsed_full = req_data.now_ms - last_ff;

   // refill timing lives here, so only the token arithmetic is left to the back end
   always_comb begin
      started_in              = started_ff;
      last_in                 = last_ff;
      head.meta.acquire       = req_data.req_type;
      head.meta.stop          = req_data.cancel | req_data.pause;
      head.meta.request_bytes = req_data.request_bytes;
      head.meta.refill        = 1'b0;
      head.elapsed            = '0;
      head.work               = '0;
      head.rem                = '0;
      if (accept && !req_data.req_type && (rate != '0)) begin
         if (!started_ff) begin
            started_in = 1'b1;
            last_in    = req_data.now_ms;
         end else if (elapsed_full != '0) begin
            last_in          = req_data.now_ms;
            head.meta.refill = 1'b1;
            head.elapsed     = (elapsed_full > TIME_BITS'(BUCKET_MS)) ?
                               ELAPSED_BITS'(BUCKET_MS) : elapsed_full[ELAPSED_BITS-1:0];
         end
      end
   end

   always_comb begin
      vld_in   = {vld_ff[NUM_STAGES-2:0], accept};
      st_in[0] = head;
      st_in[1] = st_ff[0];
      st_in[1].work = {{(WORK_BITS - RATE_BITS){1'b0}}, rate} *
                      {{(WORK_BITS - ELAPSED_BITS){1'b0}}, st_ff[0].elapsed};
      st_in[1].rem  = '0;
      for (int k = 2; k < NUM_STAGES; k++) begin
         st_in[k] = div_step(st_ff[k-1]);
      end
   end

   // credit count covers the pipeline and the queue behind it
   always_comb begin
      case ({accept, deq})
         2'b10:   used_in = used_ff + 1'b1;
         2'b01:   used_in = used_ff - 1'b1;
         default: used_in = used_ff;
      endcase
   end

   assign item_push      = vld_ff[LAST];
   assign item_data.meta = st_ff[LAST].meta;
   assign item_data.add  = st_ff[LAST].work[TOK_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         last_ff    <= '0;
         used_ff    <= '0;
         vld_ff     <= '0;
      end else begin
         started_ff <= started_in;
         last_ff    <= last_in;
         used_ff    <= used_in;
         vld_ff     <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         st_ff[k] <= st_in[k];
      end
   end

endmodule

[rtl/tbrl_back.sv]
module tbrl_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [tbrl_pkg::RATE_BITS-1:0] rate,
   input  logic                           item_empty,
   input  tbrl_pkg::tbrl_item_type        item_data,
   output logic                           item_pop,
   input  logic                           out_full,
   output logic                           out_push,
   output tbrl_pkg::tbrl_rsp_type         out_data
);

   import tbrl_pkg::*;

   logic                  fire;
   logic                  rate_zero;
   logic [TOK_BITS-1:0]   cap;
   logic [TOK_BITS:0]     sum;
   logic [TOK_BITS-1:0]   refilled;
   logic [TOK_BITS-1:0]   avail;
   logic [BYTES_BITS-1:0] need;
   logic [BYTES_BITS-1:0] take;
   logic [BYTES_BITS-1:0] left_after;
   logic [TOK_BITS-1:0]   tok_after;
   logic [TOK_BITS-1:0]   tokens_ff, tokens_in;
   logic [BYTES_BITS-1:0] remaining_ff, remaining_in;
   logic                  pending_ff, pending_in;

   assign fire     = !item_empty && !out_full;
   assign item_pop = fire;
   assign out_push = fire;

   assign rate_zero = (rate == '0);
   // half a second of tokens, never below one
   assign cap = (rate[RATE_BITS-1:1] == '0) ? TOK_BITS'(1) : rate[RATE_BITS-1:1];
   assign sum = {1'b0, tokens_ff} + {1'b0, item_data.add};
   assign refilled = !item_data.meta.refill ? tokens_ff :
                     (sum > {1'b0, cap}) ? cap : sum[TOK_BITS-1:0];

   assign avail = item_data.meta.acquire ? tokens_ff : refilled;
   assign need  = item_data.meta.acquire ? item_data.meta.request_bytes : remaining_ff;
   assign take  = ({1'b0, avail} < need) ? {1'b0, avail} : need;
   assign left_after = need - take;
   assign tok_after  = avail - take[TOK_BITS-1:0];

   always_comb begin
      tokens_in              = tokens_ff;
      remaining_in           = remaining_ff;
      pending_in             = pending_ff;
      out_data.status        = ST_IDLE;
      out_data.granted_bytes = '0;
      out_data.bytes_left    = '0;
      if (!item_data.meta.acquire) begin
         tokens_in = refilled;
         if (pending_ff) begin
            if (rate_zero) begin
               out_data.status        = ST_OK;
               out_data.granted_bytes = remaining_ff;
               remaining_in           = '0;
               pending_in             = 1'b0;
            end else if (item_data.meta.stop) begin
               out_data.status     = ST_ABORT;
               out_data.bytes_left = remaining_ff;
               remaining_in        = '0;
               pending_in          = 1'b0;
            end else begin
               tokens_in              = tok_after;
               remaining_in           = left_after;
               out_data.granted_bytes = take;
               out_data.bytes_left    = left_after;
               pending_in             = (left_after != '0);
               out_data.status        = (left_after == '0) ? ST_OK : ST_WAIT;
            end
         end
      end else if (pending_ff) begin
         out_data.status     = ST_BUSY;
         out_data.bytes_left = remaining_ff;
      end else if (rate_zero) begin
         out_data.status        = ST_OK;
         out_data.granted_bytes = item_data.meta.request_bytes;
      end else if (item_data.meta.request_bytes == '0) begin
         out_data.status = ST_OK;
      end else if (item_data.meta.stop) begin
         out_data.status     = ST_ABORT;
         out_data.bytes_left = item_data.meta.request_bytes;
      end else begin
         tokens_in              = tok_after;
         remaining_in           = left_after;
         out_data.granted_bytes = take;
         out_data.bytes_left    = left_after;
         pending_in             = (left_after != '0);
         out_data.status        = (left_after == '0) ? ST_OK : ST_WAIT;
      end
      out_data.token_level = LEVEL_BITS'(tokens_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tokens_ff    <= '0;
         remaining_ff <= '0;
         pending_ff   <= 1'b0;
      end else if (fire) begin
         tokens_ff    <= tokens_in;
         remaining_ff <= remaining_in;
         pending_ff   <= pending_in;
      end
   end

endmodule

[rtl/tbrl_checker.sv]
module tbrl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_full,
   input logic                           rsp_empty,
   input logic                           rsp_pop,
   input tbrl_pkg::tbrl_rsp_type         rsp_data
);

   import tbrl_pkg::*;

   // nothing waits and the input is open once reset is released
   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("result waiting or input closed after reset");

   // a waiting result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting result changed before transfer");

   // a completed request has nothing left
   a_ok_nothing_left: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && (rsp_data.status == ST_OK) |-> (rsp_data.bytes_left == '0))
      else $error("completed result reports bytes left");

   // idle and busy results never grant
   a_no_grant: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && ((rsp_data.status == ST_IDLE) || (rsp_data.status == ST_BUSY))
      |-> (rsp_data.granted_bytes == '0))
      else $error("idle or busy result grants bytes");

endmodule

bind token_bucket_rate_limiter_unit tbrl_checker u_tbrl_checker (.*);

[bench/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tbrl_pkg::*;

   localparam logic REQ_TICK    = 1'b0;
   localparam logic REQ_ACQUIRE = 1'b1;

   localparam int STALL_LIMIT    = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 20;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 70;
   localparam int PRESSURE_PHASE = 3;

   localparam logic [TIME_BITS-1:0]  TIME_ALL  = '1;
   localparam logic [BYTES_BITS-1:0] BYTES_ALL = '1;
   localparam logic [RATE_BITS-1:0]  RATE_ALL  = '1;
   localparam logic [LEVEL_BITS-1:0] LEVEL_ALL = '1;

   typedef enum logic {ROW_ITEM, ROW_RATE} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      tbrl_req_type          item;
      bit                    fixed;
      tbrl_rsp_type          rsp;
      logic [RATE_BITS-1:0]  rate;
   } dir_row_type;

   typedef struct {
      bit           fixed;
      tbrl_rsp_type rsp;
   } typed_rsp_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   tbrl_req_type         req_data = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   tbrl_rsp_type         rsp_data;
   logic                 csr_we = 1'b0;
   logic [RATE_BITS-1:0] csr_wdata = '0;

   // bucket as the block should hold it
   logic [RATE_BITS-1:0]  tb_rate = '0;
   logic [TOK_BITS-1:0]   tokens_held = '0;
   logic [TIME_BITS-1:0]  last_stamp = '0;
   logic                  stamp_valid = 1'b0;
   logic [BYTES_BITS-1:0] owed_bytes = '0;
   logic                  owing = 1'b0;

   tbrl_rsp_type  outcome_q[$];
   typed_rsp_type typed_q[$];
   dir_row_type   dir_tab[$];

   logic [TIME_BITS-1:0] cur_ms = '0;
   bit                   hold_off = 1'b0;
   int                   flaws = 0;
   int                   idle_cycles = 0;

   token_bucket_rate_limiter_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic status_type serve_owed(input logic halt,
                                             output logic [BYTES_BITS-1:0] granted);
      logic [63:0] take;
      granted = '0;
      if (tb_rate == '0) begin
         granted    = owed_bytes;
         owed_bytes = '0;
         owing      = 1'b0;
         return ST_OK;
      end
      if (halt) begin
         owing = 1'b0;
         return ST_ABORT;
      end
      take        = (tokens_held < owed_bytes) ? tokens_held : owed_bytes;
      tokens_held = tokens_held - take[TOK_BITS-1:0];
      owed_bytes  = owed_bytes - take[BYTES_BITS-1:0];
      granted     = take[BYTES_BITS-1:0];
      if (owed_bytes == '0) begin
         owing = 1'b0;
         return ST_OK;
      end
      return ST_WAIT;
   endfunction

   function automatic tbrl_rsp_type bucket_step(tbrl_req_type it);
      tbrl_rsp_type         r;
      logic                 halt;
      logic [TIME_BITS-1:0] gap_ms;
      logic [63:0]          span, gain, ceiling, sum;
      r    = '0;
      halt = it.cancel | it.pause;
      if (it.req_type == REQ_TICK) begin
         if (tb_rate != '0) begin
            if (!stamp_valid) begin
               stamp_valid = 1'b1;
               last_stamp  = it.now_ms;
            end else begin
               // difference wraps at the timestamp width
               gap_ms = it.now_ms - last_stamp;
               if (gap_ms != '0) begin
                  last_stamp = it.now_ms;
                  span    = (gap_ms > BUCKET_MS) ? 64'(BUCKET_MS) : 64'(gap_ms);
                  gain    = 64'(tb_rate) * span / 64'(MS_PER_S);
                  ceiling = 64'(tb_rate) * 64'(BUCKET_MS) / 64'(MS_PER_S);
                  if (ceiling == 64'd0)
                     ceiling = 64'd1;
                  sum = 64'(tokens_held) + gain;
                  if (sum > ceiling)
                     sum = ceiling;
                  tokens_held = sum[TOK_BITS-1:0];
               end
            end
         end
         if (owing) begin
            r.status     = serve_owed(halt, r.granted_bytes);
            r.bytes_left = owed_bytes;
         end
      end else if (owing) begin
         r.status     = ST_BUSY;
         r.bytes_left = owed_bytes;
      end else if (tb_rate == '0) begin
         r.status        = ST_OK;
         r.granted_bytes = it.request_bytes;
      end else if (it.request_bytes == '0) begin
         r.status = ST_OK;
      end else if (halt) begin
         r.status     = ST_ABORT;
         r.bytes_left = it.request_bytes;
      end else begin
         owed_bytes   = it.request_bytes;
         owing        = 1'b1;
         r.status     = serve_owed(1'b0, r.granted_bytes);
         r.bytes_left = owed_bytes;
      end
      if (!owing)
         owed_bytes = '0;
      r.token_level = tokens_held;
      return r;
   endfunction

   // mostly steady time steps and acquires sized to the rate, some wild values
   function automatic tbrl_req_type next_item();
      tbrl_req_type it;
      logic [63:0]  w, v;
      int           pick;
      w    = {$urandom, $urandom};
      v    = {$urandom, $urandom};
      it   = '0;
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
         it.req_type      = REQ_TICK;
         it.request_bytes = w[BYTES_BITS-1:0];
         pick = $urandom_range(0, 99);
         if (pick < 80)
            cur_ms = cur_ms + TIME_BITS'($urandom_range(0, 120));
         else if (pick < 88)
            cur_ms = cur_ms + TIME_BITS'($urandom_range(400, 3000));
         else if (pick < 94)
            cur_ms = cur_ms - TIME_BITS'($urandom_range(1, 2000));
         else
            cur_ms = v[TIME_BITS-1:0];
         it.now_ms = cur_ms;
      end else begin
         it.req_type = REQ_ACQUIRE;
         it.now_ms   = v[TIME_BITS-1:0];
         pick = $urandom_range(0, 99);
         if (pick < 15)
            it.request_bytes = BYTES_BITS'($urandom_range(0, 40));
         else if (pick < 85)
            it.request_bytes = BYTES_BITS'((64'(tb_rate) / 64'(MS_PER_S) + 64'd1)
                                           * 64'($urandom_range(1, 700)));
         else
            it.request_bytes = w[BYTES_BITS-1:0];
      end
      it.cancel = ($urandom_range(0, 15) == 0);
      it.pause  = ($urandom_range(0, 15) == 0);
      return it;
   endfunction

   function automatic dir_row_type item_row(logic acq, logic [TIME_BITS-1:0] stamp,
                                            logic [BYTES_BITS-1:0] bytes, logic cncl,
                                            logic paus, bit fixed, status_type st,
                                            logic [BYTES_BITS-1:0] granted,
                                            logic [BYTES_BITS-1:0] left,
                                            logic [LEVEL_BITS-1:0] level);
      dir_row_type r;
      r.kind                = ROW_ITEM;
      r.item.req_type       = acq;
      r.item.now_ms         = stamp;
      r.item.request_bytes  = bytes;
      r.item.cancel         = cncl;
      r.item.pause          = paus;
      r.fixed               = fixed;
      r.rsp.status          = st;
      r.rsp.granted_bytes   = granted;
      r.rsp.bytes_left      = left;
      r.rsp.token_level     = level;
      r.rate                = '0;
      return r;
   endfunction

   function automatic dir_row_type rate_row(logic [RATE_BITS-1:0] value);
      dir_row_type r;
      r       = item_row(REQ_TICK, '0, '0, 1'b0, 1'b0, 1'b0, ST_IDLE, '0, '0, '0);
      r.kind  = ROW_RATE;
      r.rate  = value;
      return r;
   endfunction

   task automatic send_item(tbrl_req_type item, bit fixed, tbrl_rsp_type rsp);
      typed_rsp_type note;
      note.fixed = fixed;
      note.rsp   = rsp;
      typed_q.push_back(note);
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!(req_push && !req_full));
   endtask

   // only once every transfer in flight has come back out
   task automatic write_rate(logic [RATE_BITS-1:0] value);
      req_push <= 1'b0;
      @(posedge clock);
      while (outcome_q.size() != 0)
         @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we  <= 1'b0;
      tb_rate  = value;
   endtask

   task automatic run_phase(int count, bit no_gaps);
      int burst_left;
      int gap;
      burst_left = $urandom_range(1, 30);
      for (int i = 0; i < count; i++) begin
         send_item(next_item(), 1'b0, '0);
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (!no_gaps && gap > 0) begin
               req_push <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         flaws++;
         $display("%0t %s: expected %0d actual %0d", $time, what, want, got);
      end
   endtask

   initial begin : receiver
      int mode;
      int left_in_mode;
      mode         = 0;
      left_in_mode = 0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            if (left_in_mode == 0) begin
               mode         = $urandom_range(0, 3);
               left_in_mode = $urandom_range(8, 80);
            end
            left_in_mode--;
            case (mode)
               0: rsp_pop <= 1'b1;
               1: rsp_pop <= 1'($urandom_range(0, 1));
               2: rsp_pop <= ($urandom_range(0, 3) == 0);
               default: rsp_pop <= ((left_in_mode % 5) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : monitor
      typed_rsp_type note;
      tbrl_rsp_type  want;
      bit            moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_push && !req_full) begin
            note = typed_q.pop_front();
            want = bucket_step(req_data);
            if (note.fixed)
               want = note.rsp;
            outcome_q.push_back(want);
            moved = 1'b1;
         end
         if (rsp_pop && !rsp_empty) begin
            moved = 1'b1;
            if (outcome_q.size() == 0) begin
               flaws++;
               $display("%0t unexpected result: expected none actual %p", $time, rsp_data);
            end else begin
               want = outcome_q.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_data.status));
               check_field("granted_bytes", 64'(want.granted_bytes),
                           64'(rsp_data.granted_bytes));
               check_field("bytes_left", 64'(want.bytes_left), 64'(rsp_data.bytes_left));
               check_field("token_level", 64'(want.token_level), 64'(rsp_data.token_level));
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin : stimulus
      dir_row_type          row;
      logic [63:0]          rnd;
      logic [RATE_BITS-1:0] phase_rate;

      // unlimited after reset
      dir_tab.push_back(item_row(REQ_TICK, '0, '0, 0, 0, 1, ST_IDLE, '0, '0, '0));
      dir_tab.push_back(item_row(REQ_ACQUIRE, '0, BYTES_ALL, 0, 0, 1, ST_OK, BYTES_ALL, '0, '0));
      dir_tab.push_back(item_row(REQ_ACQUIRE, '0, 5, 1, 0, 1, ST_OK, 5, '0, '0));
      // one byte per ms, bucket holds 500
      dir_tab.push_back(rate_row(1000));
      dir_tab.push_back(item_row(REQ_TICK, 100, '0, 0, 0, 1, ST_IDLE, '0, '0, '0));
      dir_tab.push_back(item_row(REQ_TICK, 350, '0, 0, 0, 1, ST_IDLE, '0, '0, 250));
      dir_tab.push_back(item_row(REQ_ACQUIRE, '0, '0, 0, 0, 1, ST_OK, '0, '0, 250));
      dir_tab.push_back(item_row(REQ_ACQUIRE, '0, 100, 1, 0, 1, ST_ABORT, '0, 100, 250));
      dir_tab.push_back(item_row(REQ_ACQUIRE, '0, 100, 0, 1, 1, ST_ABORT, '0, 100, 250));
      dir_tab.push_back(item_row(REQ_ACQUIRE, '0, 400, 0, 0, 1, ST_WAIT, 250, 150, '0));
      dir_tab.push_back(item_row(REQ_ACQUIRE, '0, 7, 0, 0, 1, ST_BUSY, '0, 150, '0));
      // same timestamp again: no refill
      dir_tab.push_back(item_row(REQ_TICK, 350, '0, 0, 0, 1, ST_WAIT, '0, 150, '0));
      dir_tab.push_back(item_row(REQ_TICK, 450, '0, 0, 0, 1, ST_WAIT, 100, 50, '0));
      dir_tab.push_back(item_row(REQ_TICK, 2000, '0, 0, 0, 1, ST_OK, 50, '0, 450));
      // time going backwards wraps and saturates
      dir_tab.push_back(item_row(REQ_TICK, 1000, '0, 0, 0, 1, ST_IDLE, '0, '0, 500));
      dir_tab.push_back(item_row(REQ_ACQUIRE, '0, 600, 0, 0, 1, ST_WAIT, 500, 100, '0));
      dir_tab.push_back(item_row(REQ_TICK, 1010, '0, 1, 0, 1, ST_ABORT, '0, 100, 10));
      dir_tab.push_back(item_row(REQ_ACQUIRE, '0, 20, 0, 0, 1, ST_WAIT, 10, 10, '0));
      // pending request finishes for free once limiting is off
      dir_tab.push_back(rate_row(0));
      dir_tab.push_back(item_row(REQ_TICK, 5, '0, 0, 0, 1, ST_OK, 10, '0, '0));
      dir_tab.push_back(rate_row(1));
      dir_tab.push_back(item_row(REQ_TICK, TIME_ALL, '0, 0, 0, 1, ST_IDLE, '0, '0, '0));
      dir_tab.push_back(rate_row(RATE_ALL));
      dir_tab.push_back(item_row(REQ_TICK, 499, '0, 0, 0, 1, ST_IDLE, '0, '0, LEVEL_ALL));
      dir_tab.push_back(item_row(REQ_ACQUIRE, '0, BYTES_ALL, 0, 0, 1, ST_WAIT,
                                 40'h7F_FFFF_FFFF, 40'h80_0000_0000, '0));
      dir_tab.push_back(item_row(REQ_TICK, 500, '0, 0, 0, 0, ST_IDLE, '0, '0, '0));
      dir_tab.push_back(item_row(REQ_TICK, 500, '0, 0, 1, 0, ST_IDLE, '0, '0, '0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         row = dir_tab[i];
         if (row.kind == ROW_RATE)
            write_rate(row.rate);
         else
            send_item(row.item, row.fixed, row.rsp);
      end

      rnd    = {$urandom, $urandom};
      cur_ms = rnd[TIME_BITS-1:0];
      for (int p = 0; p < PHASES; p++) begin
         rnd = {$urandom, $urandom};
         case (p)
            0: phase_rate = 1000;
            1: phase_rate = '0;
            2: phase_rate = RATE_ALL;
            3: phase_rate = 2000;
            4: phase_rate = 1;
            5: phase_rate = 999;
            7: phase_rate = RATE_BITS'($urandom_range(1, 100000));
            8: phase_rate = {1'b1, {(RATE_BITS-1){1'b0}}};
            default: phase_rate = rnd[RATE_BITS-1:0];
         endcase
         write_rate(phase_rate);
         // receiver stops for a long while so the input backs up
         if (p == PRESSURE_PHASE)
            hold_off = 1'b1;
         run_phase(PHASE_ITEMS, p == PRESSURE_PHASE);
      end

      req_push <= 1'b0;
      @(posedge clock);
      while (outcome_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (flaws == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
